[hw/rtl/tcmc_pkg.sv]
// shared types and constants of the tachometer and countdown block
`default_nettype none

package tcmc_pkg;

    // pulse counter width default
    localparam int COUNT_WIDTH_DEF = 16;

    // port widths
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 24;
    localparam int S_USER_W    = 3;
    localparam int M_DATA_W    = 48;
    localparam int SPEED_W     = 16;

    // time and speed limits
    localparam logic [5:0]         SEC_LAST          = 6'd59;
    localparam logic [5:0]         MIN_LAST          = 6'd59;
    localparam logic [5:0]         RPM_PER_PULSE_RST = 6'd60;
    localparam logic [SPEED_W-1:0] SPEED_MAX         = 16'hFFFF;

    // item kinds
    typedef enum logic [2:0] {
        KIND_PULSE     = 3'd0,
        KIND_TICK      = 3'd1,
        KIND_START     = 3'd2,
        KIND_SET       = 3'd3,
        KIND_INC       = 3'd4,
        KIND_DEC       = 3'd5,
        KIND_LOAD      = 3'd6,
        KIND_CLEAR_RUN = 3'd7
    } t_kind;

    // view sequence states
    typedef enum logic [2:0] {
        VIEW_HOME      = 3'd0,
        VIEW_COUNTDOWN = 3'd1,
        VIEW_SETUP_A   = 3'd2,
        VIEW_SETUP_B   = 3'd3,
        VIEW_PWM       = 3'd4,
        VIEW_SETUP_C   = 3'd5
    } t_view;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RPM_PER_PULSE  = 2'd0,
        CFG_TARGET_RPM     = 2'd1,
        CFG_TARGET_HOURS   = 2'd2,
        CFG_TARGET_MINUTES = 2'd3
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic [5:0]         rpm_per_pulse;
        logic [SPEED_W-1:0] target_rpm;
        logic [6:0]         target_hours;
        logic [5:0]         target_minutes;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [2:0]         view;
        logic               run_mode;
        logic               pwm_on;
        logic [SPEED_W-1:0] speed_rpm;
        logic [6:0]         hours_left;
        logic [5:0]         minutes_left;
        logic [5:0]         seconds_left;
        logic               cycle_done;
        logic               inc_event;
        logic               dec_event;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/tcmc_cfg.sv]
// configuration registers of the tachometer and countdown block
`default_nettype none

module tcmc_cfg (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tcmc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [tcmc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output tcmc_pkg::t_cfg                            o_cfg
);

    tcmc_pkg::t_cfg r_cfg;

    // register writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rpm_per_pulse  <= tcmc_pkg::RPM_PER_PULSE_RST;
            r_cfg.target_rpm     <= '0;
            r_cfg.target_hours   <= '0;
            r_cfg.target_minutes <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcmc_pkg::CFG_RPM_PER_PULSE:  r_cfg.rpm_per_pulse  <= i_cfg_data[5:0];
                tcmc_pkg::CFG_TARGET_RPM:     r_cfg.target_rpm     <= i_cfg_data[15:0];
                tcmc_pkg::CFG_TARGET_HOURS:   r_cfg.target_hours   <= i_cfg_data[6:0];
                tcmc_pkg::CFG_TARGET_MINUTES: r_cfg.target_minutes <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hw/rtl/tcmc_core.sv]
// state update of tachometer, countdown and view sequence for one item
`default_nettype none

module tcmc_core #(
    parameter int COUNT_WIDTH = tcmc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire tcmc_pkg::t_kind i_kind,
    input  wire logic [6:0]      i_load_hours,
    input  wire logic [5:0]      i_load_minutes,
    input  wire logic [5:0]      i_load_seconds,
    input  wire tcmc_pkg::t_cfg  i_cfg,
    output tcmc_pkg::t_result    o_res
);

    localparam int PROD_W = (COUNT_WIDTH + 6 > 17) ? COUNT_WIDTH + 6 : 17;
    localparam logic [COUNT_WIDTH-1:0] CNT_FULL = '1;

    tcmc_pkg::t_view                r_view;
    tcmc_pkg::t_view                n_view;
    logic [COUNT_WIDTH-1:0]         r_pulse_count;
    logic [COUNT_WIDTH-1:0]         n_pulse_count;
    logic [tcmc_pkg::SPEED_W-1:0]   r_speed;
    logic [tcmc_pkg::SPEED_W-1:0]   n_speed;
    logic                           r_run;
    logic                           n_run;
    logic                           r_pwm;
    logic                           n_pwm;
    logic [6:0]                     r_hours;
    logic [6:0]                     n_hours;
    logic [5:0]                     r_minutes;
    logic [5:0]                     n_minutes;
    logic [5:0]                     r_seconds;
    logic [5:0]                     n_seconds;
    logic                           r_done;
    logic                           n_done;

    logic                           active;
    logic [PROD_W-1:0]              prod;
    logic                           prod_sat;
    logic [6:0]                     step_hours;
    logic [5:0]                     step_minutes;
    logic [5:0]                     step_seconds;
    logic                           at_zero;
    logic                           step_zero;
    logic                           arm_ok;

    assign active = r_run | r_pwm;

    // speed from pulses in the window
    assign prod     = PROD_W'(r_pulse_count) * PROD_W'(i_cfg.rpm_per_pulse);
    assign prod_sat = |prod[PROD_W-1:tcmc_pkg::SPEED_W];

    // one second down with borrow
    assign at_zero = (r_hours == '0) && (r_minutes == '0) && (r_seconds == '0);
    always_comb begin
        step_hours   = r_hours;
        step_minutes = r_minutes;
        step_seconds = r_seconds - 6'd1;
        if (r_seconds == '0) begin
            step_seconds = tcmc_pkg::SEC_LAST;
            if (r_minutes == '0) begin
                step_minutes = tcmc_pkg::MIN_LAST;
                step_hours   = r_hours - 7'd1;
            end else begin
                step_minutes = r_minutes - 6'd1;
            end
        end
    end
    assign step_zero = (step_hours == '0) && (step_minutes == '0) && (step_seconds == '0);

    assign arm_ok = (i_cfg.target_rpm != '0) &&
                    ((i_cfg.target_hours != '0) || (i_cfg.target_minutes != '0));

    // next state for the current item
    always_comb begin
        n_view        = r_view;
        n_pulse_count = r_pulse_count;
        n_speed       = r_speed;
        n_run         = r_run;
        n_pwm         = r_pwm;
        n_hours       = r_hours;
        n_minutes     = r_minutes;
        n_seconds     = r_seconds;
        n_done        = r_done;
        case (i_kind)
            tcmc_pkg::KIND_PULSE: begin
                if (active && (r_pulse_count != CNT_FULL)) begin
                    n_pulse_count = r_pulse_count + 1'b1;
                end
            end
            tcmc_pkg::KIND_TICK: begin
                if (active) begin
                    n_speed       = prod_sat ? tcmc_pkg::SPEED_MAX
                                             : prod[tcmc_pkg::SPEED_W-1:0];
                    n_pulse_count = '0;
                    if (r_view == tcmc_pkg::VIEW_COUNTDOWN) begin
                        if (at_zero) begin
                            n_done = 1'b1;
                        end else begin
                            n_hours   = step_hours;
                            n_minutes = step_minutes;
                            n_seconds = step_seconds;
                            if (step_zero) begin
                                n_done = 1'b1;
                            end
                        end
                    end
                end
            end
            tcmc_pkg::KIND_START: begin
                case (r_view)
                    tcmc_pkg::VIEW_COUNTDOWN: n_view = tcmc_pkg::VIEW_HOME;
                    tcmc_pkg::VIEW_HOME: begin
                        n_view = tcmc_pkg::VIEW_COUNTDOWN;
                        if (arm_ok) begin
                            n_run = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tcmc_pkg::KIND_SET: begin
                case (r_view)
                    tcmc_pkg::VIEW_HOME:      n_view = tcmc_pkg::VIEW_SETUP_A;
                    tcmc_pkg::VIEW_COUNTDOWN: n_view = tcmc_pkg::VIEW_HOME;
                    tcmc_pkg::VIEW_SETUP_A:   n_view = tcmc_pkg::VIEW_SETUP_B;
                    tcmc_pkg::VIEW_SETUP_B: begin
                        n_view = tcmc_pkg::VIEW_PWM;
                        n_pwm  = 1'b1;
                    end
                    tcmc_pkg::VIEW_PWM:       n_view = tcmc_pkg::VIEW_SETUP_C;
                    tcmc_pkg::VIEW_SETUP_C:   n_view = tcmc_pkg::VIEW_HOME;
                    default: begin
                    end
                endcase
            end
            tcmc_pkg::KIND_LOAD: begin
                n_hours   = i_load_hours;
                n_minutes = i_load_minutes;
                n_seconds = i_load_seconds;
                n_done    = 1'b0;
            end
            tcmc_pkg::KIND_CLEAR_RUN: begin
                n_run  = 1'b0;
                n_done = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view        <= tcmc_pkg::VIEW_HOME;
            r_pulse_count <= '0;
            r_speed       <= '0;
            r_run         <= 1'b0;
            r_pwm         <= 1'b0;
            r_hours       <= '0;
            r_minutes     <= '0;
            r_seconds     <= '0;
            r_done        <= 1'b0;
        end else if (i_fire) begin
            r_view        <= n_view;
            r_pulse_count <= n_pulse_count;
            r_speed       <= n_speed;
            r_run         <= n_run;
            r_pwm         <= n_pwm;
            r_hours       <= n_hours;
            r_minutes     <= n_minutes;
            r_seconds     <= n_seconds;
            r_done        <= n_done;
        end
    end

    // result reflects the state after this item
    always_comb begin
        o_res.view         = n_view;
        o_res.run_mode     = n_run;
        o_res.pwm_on       = n_pwm;
        o_res.speed_rpm    = n_speed;
        o_res.hours_left   = n_hours;
        o_res.minutes_left = n_minutes;
        o_res.seconds_left = n_seconds;
        o_res.cycle_done   = n_done;
        o_res.inc_event    = (i_kind == tcmc_pkg::KIND_INC);
        o_res.dec_event    = (i_kind == tcmc_pkg::KIND_DEC);
    end

endmodule

`default_nettype wire

[hw/rtl/tachometer_countdown_mode_control.sv]
// top level: input register, state update core and result register
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser kind, tdata load time
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata view, flags, speed, time
//  cfg       in         i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
//  an item is held in the input register; when it fires, the core updates state
//  and the result register takes the new result, one item per cycle sustained
//  while m_axis_tready stays high
//  the result register frees while it is taken, so a stall only holds back the
//  input register once the result waits
//  synchronous active-low reset clears valids and core state, view returns to home
`default_nettype none

module tachometer_countdown_mode_control #(
    parameter int COUNT_WIDTH = tcmc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input items
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [6:0] load_hours, [12:7] load_minutes, [18:13] load_seconds, rest zero
    input  wire logic [tcmc_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // [2:0] kind
    input  wire logic [tcmc_pkg::S_USER_W-1:0]     s_axis_tuser,
    // result items
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [2:0] view, [3] run_mode, [4] pwm_on, [20:5] speed_rpm, [27:21] hours_left,
    // [33:28] minutes_left, [39:34] seconds_left, [40] cycle_done,
    // [41] inc_event, [42] dec_event, rest zero
    output logic [tcmc_pkg::M_DATA_W-1:0]          m_axis_tdata,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [tcmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [tcmc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                  r_in_valid;
    tcmc_pkg::t_kind       r_kind;
    logic [6:0]            r_load_hours;
    logic [5:0]            r_load_minutes;
    logic [5:0]            r_load_seconds;
    logic                  r_out_valid;
    tcmc_pkg::t_result     r_out;

    logic                  advance;
    logic                  fire;
    logic                  in_take;
    tcmc_pkg::t_cfg        cfg;
    tcmc_pkg::t_result     res;

    // flow control
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind         <= tcmc_pkg::t_kind'(s_axis_tuser[2:0]);
            r_load_hours   <= s_axis_tdata[6:0];
            r_load_minutes <= s_axis_tdata[12:7];
            r_load_seconds <= s_axis_tdata[18:13];
        end
    end

    tcmc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tcmc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_kind         (r_kind),
        .i_load_hours   (r_load_hours),
        .i_load_minutes (r_load_minutes),
        .i_load_seconds (r_load_seconds),
        .i_cfg          (cfg),
        .o_res          (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    // result packing
    assign m_axis_tvalid        = r_out_valid;
    assign m_axis_tdata[2:0]    = r_out.view;
    assign m_axis_tdata[3]      = r_out.run_mode;
    assign m_axis_tdata[4]      = r_out.pwm_on;
    assign m_axis_tdata[20:5]   = r_out.speed_rpm;
    assign m_axis_tdata[27:21]  = r_out.hours_left;
    assign m_axis_tdata[33:28]  = r_out.minutes_left;
    assign m_axis_tdata[39:34]  = r_out.seconds_left;
    assign m_axis_tdata[40]     = r_out.cycle_done;
    assign m_axis_tdata[41]     = r_out.inc_event;
    assign m_axis_tdata[42]     = r_out.dec_event;
    assign m_axis_tdata[47:43]  = '0;

endmodule

`default_nettype wire
